/* hw/rtl/ptcs_pkg.sv */
package ptcs_pkg;

  typedef enum logic [2:0] {
    BIOME_DEEP     = 3'd0,
    BIOME_SHALLOW  = 3'd1,
    BIOME_SAND     = 3'd2,
    BIOME_GRASS    = 3'd3,
    BIOME_FOREST   = 3'd4,
    BIOME_MOUNTAIN = 3'd5,
    BIOME_SNOW     = 3'd6
  } biome_t;

  typedef struct packed {
    logic [5:0] cell_col;
    logic [4:0] cell_row;
  } ptcs_in_t;

  typedef struct packed {
    biome_t     biome;
    logic [7:0] left_glyph;
    logic [7:0] right_glyph;
    logic [7:0] fore_colour;
    logic [7:0] back_colour;
    logic       gold_here;
  } ptcs_out_t;

  localparam logic [1:0] REG_HASH_SEED = 2'd0;
  localparam logic [1:0] REG_SCROLL_X  = 2'd1;
  localparam logic [1:0] REG_SCROLL_Y  = 2'd2;

  localparam logic [7:0] GOLD_CODE   = 8'h5A;
  localparam logic [7:0] GOLD_COLOUR = 8'hFC;

  localparam logic [7:0] TH_DEEP     = 8'd55;
  localparam logic [7:0] TH_SHALLOW  = 8'd75;
  localparam logic [7:0] TH_SAND     = 8'd95;
  localparam logic [7:0] TH_GRASS    = 8'd165;
  localparam logic [7:0] TH_FOREST   = 8'd195;
  localparam logic [7:0] TH_MOUNTAIN = 8'd225;

  function automatic logic [7:0] biome_colour(input biome_t b);
    case (b)
      BIOME_DEEP:     biome_colour = 8'h03;
      BIOME_SHALLOW:  biome_colour = 8'h14;
      BIOME_SAND:     biome_colour = 8'hF5;
      BIOME_GRASS:    biome_colour = 8'h39;
      BIOME_FOREST:   biome_colour = 8'h12;
      BIOME_MOUNTAIN: biome_colour = 8'hA2;
      default:        biome_colour = 8'hFF;
    endcase
  endfunction

  function automatic logic [15:0] biome_glyphs(input biome_t b, input logic [1:0] vi);
    case (b)
      BIOME_DEEP:     biome_glyphs = 16'h7E20;
      BIOME_SHALLOW:  biome_glyphs = 16'hB020;
      BIOME_SAND:     biome_glyphs = 16'hB020;
      BIOME_GRASS: begin
        case (vi)
          2'd0:    biome_glyphs = 16'hB106;
          2'd1:    biome_glyphs = 16'hB005;
          2'd2:    biome_glyphs = 16'hB10F;
          default: biome_glyphs = 16'hB006;
        endcase
      end
      BIOME_FOREST: begin
        case (vi)
          2'd0:    biome_glyphs = 16'hB21E;
          2'd1:    biome_glyphs = 16'hB205;
          2'd2:    biome_glyphs = 16'hB11E;
          default: biome_glyphs = 16'hB2B2;
        endcase
      end
      BIOME_MOUNTAIN: biome_glyphs = 16'h1E20;
      default:        biome_glyphs = 16'hDB20;
    endcase
  endfunction

endpackage

/* hw/rtl/procedural_terrain_cell_shader.sv */
// Channel   Ports                                      Handshake
// in        start, busy, in_data (ptcs_in_t)           taken when start && !busy
// out       out_valid, out_data (ptcs_out_t)           one-cycle strobe, no stall
// cfg       psel, penable, pwrite, paddr, pwdata,      APB write, pready tied high
//           prdata, pready
//
// One word per clock; busy is always low. A taken word is held in the input register,
// then goes through the hash and lookup logic into the result register.
// rst_n is synchronous, active low: clears the valid flags and the config registers.
// The receiver cannot stall; results are never held.
module procedural_terrain_cell_shader
  import ptcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ptcs_in_t    in_data,
  output logic        out_valid,
  output ptcs_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] hash_seed_r;
  logic [15:0] scroll_x_r;
  logic [15:0] scroll_y_r;

  logic        in_valid_r;
  ptcs_in_t    in_r;
  logic        out_valid_r;
  ptcs_out_t   out_r;
  ptcs_out_t   out_nxt;

  logic        wr_en;
  logic [1:0]  reg_idx;

  logic [31:0] wx, wy, h0, h1, h2, h3, h4, h5, h6;
  biome_t      bio;
  logic [7:0]  base_col, var_col;
  logic [7:0]  au;
  logic [15:0] glyphs;
  logic        gold;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      REG_HASH_SEED: prdata = hash_seed_r;
      REG_SCROLL_X:  prdata = {16'd0, scroll_x_r};
      REG_SCROLL_Y:  prdata = {16'd0, scroll_y_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r <= 32'd0;
      scroll_x_r  <= 16'd0;
      scroll_y_r  <= 16'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HASH_SEED: hash_seed_r <= pwdata;
        REG_SCROLL_X:  scroll_x_r  <= pwdata[15:0];
        REG_SCROLL_Y:  scroll_y_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  function automatic logic [2:0] nudge(input logic [2:0] c, input logic up,
                                       input logic [2:0] top);
    if (up) nudge = (c < top) ? c + 3'd1 : top;
    else    nudge = (c != 3'd0) ? c - 3'd1 : 3'd0;
  endfunction

  always_comb begin
    logic [2:0] r, g, b;
    logic [2:0] bn;
    wx = {26'd0, in_r.cell_col} + {{16{scroll_x_r[15]}}, scroll_x_r};
    wy = {27'd0, in_r.cell_row} + {{16{scroll_y_r[15]}}, scroll_y_r};
    h0 = hash_seed_r ^ (wx << 7) ^ (wy << 20);
    h1 = h0 ^ (h0 << 13);
    h2 = h1 ^ (h1 >> 17);
    h3 = h2 ^ (h2 << 5);
    h4 = h3 ^ (wy << 3) ^ (wx << 16);
    h5 = h4 ^ (h4 >> 11);
    h6 = h5 ^ (h5 << 7);

    if (h6[7:0] <= TH_DEEP)          bio = BIOME_DEEP;
    else if (h6[7:0] <= TH_SHALLOW)  bio = BIOME_SHALLOW;
    else if (h6[7:0] <= TH_SAND)     bio = BIOME_SAND;
    else if (h6[7:0] <= TH_GRASS)    bio = BIOME_GRASS;
    else if (h6[7:0] <= TH_FOREST)   bio = BIOME_FOREST;
    else if (h6[7:0] <= TH_MOUNTAIN) bio = BIOME_MOUNTAIN;
    else                             bio = BIOME_SNOW;

    base_col = biome_colour(bio);
    r = base_col[7:5];
    g = base_col[4:2];
    b = {1'b0, base_col[1:0]};
    case (h6[9:8])
      2'd0:    r = nudge(r, h6[10], 3'd7);
      2'd1:    g = nudge(g, h6[10], 3'd7);
      2'd2:    b = nudge(b, h6[10], 3'd3);
      default: ;
    endcase
    bn = b;
    var_col = {r, g, bn[1:0]};

    au     = h6[23:16];
    gold   = (au == GOLD_CODE);
    glyphs = biome_glyphs(bio, au[5:4]);

    out_nxt.biome       = bio;
    out_nxt.left_glyph  = glyphs[15:8];
    out_nxt.right_glyph = glyphs[7:0];
    out_nxt.fore_colour = gold ? GOLD_COLOUR : var_col;
    out_nxt.back_colour = var_col;
    out_nxt.gold_here   = gold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_r <= in_data;
    if (in_valid_r)     out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // every accepted word yields a strobe once it has passed the input and result registers
  a_word_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> ##1 !out_valid)
    else $error("result without accepted word");

  a_fore_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gold_here ? (out_data.fore_colour == GOLD_COLOUR)
                                      : (out_data.fore_colour == out_data.back_colour)))
    else $error("foreground colour inconsistent with gold flag");

endmodule
